@@ design/calendar_add_days_inclusive_core_assert.svh @@
// Assertion macros for the date-advance core.
// Used by the top level only; no other dependencies.
`ifndef CALENDAR_ADD_DAYS_INCLUSIVE_CORE_ASSERT_SVH
`define CALENDAR_ADD_DAYS_INCLUSIVE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CADI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define CADI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define CADI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CADI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/cadi_pkg.sv @@
// Shared types, constants and month-length function for the date-advance core.
// No dependencies.
package cadi_pkg;

    localparam int YEAR_W  = 16;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 9;
    localparam int TALLY_W = 16;

    localparam logic [MONTH_W-1:0] FIRST_MONTH     = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY        = 4'd2;
    localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
    localparam logic [DAY_W-1:0]   LEAP_FEB_LEN    = 5'd29;

    // indexed by month; codes outside 1..12 have length zero
    localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic fin;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic hit;
    } t_status;

    // leap rule: every fourth year, no century exception
    function automatic logic [DAY_W-1:0] days_in(input logic [YEAR_W-1:0] year,
                                                 input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] len;
        len = MONTH_LEN[month];
        if (month == FEBRUARY && year[1:0] == 2'b00) begin
            len = LEAP_FEB_LEN;
        end
        return len;
    endfunction

endpackage

@@ design/cadi_req_if.sv @@
// Request channel: start date and inclusive day count, valid/ready handshake.
// Depends on cadi_pkg.
interface cadi_req_if;
    import cadi_pkg::*;

    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [COUNT_W-1:0] day_count;

    modport source (output valid, start_year, start_month, start_day, day_count,
                    input ready);
    modport sink   (input valid, start_year, start_month, start_day, day_count,
                    output ready);
endinterface

@@ design/cadi_rsp_if.sv @@
// Response channel: resulting date and found flag, valid/ready handshake.
// Depends on cadi_pkg.
interface cadi_rsp_if;
    import cadi_pkg::*;

    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  end_year;
    logic [MONTH_W-1:0] end_month;
    logic [DAY_W-1:0]   end_day;
    logic               found;

    modport source (output valid, end_year, end_month, end_day, found, input ready);
    modport sink   (input valid, end_year, end_month, end_day, found, output ready);
endinterface

@@ design/calendar_add_days_inclusive_core.sv @@
// Date advance by an inclusive day count, one month step per cycle.
// Flow: load, then month steps until the target is found in walk step k (1..MONTH_STEPS),
// then day fix-up and commit; a miss commits after MONTH_STEPS steps. Output stalls hold the commit.
// One request at a time: the next is accepted in the cycle after the result is loaded
// into the output register.
// Reset (synchronous, active low) idles the controller and drops output valid; datapath not reset.
`include "calendar_add_days_inclusive_core_assert.svh"

module calendar_add_days_inclusive_core #(
    parameter int MONTH_STEPS = 13
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cadi_req_if.sink   i_req,
    cadi_rsp_if.source o_rsp
);
    import cadi_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;
    logic    out_valid;

    cadi_ctrl #(
        .MONTH_STEPS(MONTH_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid)
    );

    cadi_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_start_year  (i_req.start_year),
        .i_start_month (i_req.start_month),
        .i_start_day   (i_req.start_day),
        .i_day_count   (i_req.day_count),
        .o_status      (status),
        .o_end_year    (o_rsp.end_year),
        .o_end_month   (o_rsp.end_month),
        .o_end_day     (o_rsp.end_day),
        .o_found       (o_rsp.found)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;

    // a taken request keeps the core busy for at least the next cycle
    `CADI_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, i_req.valid && in_ready, !in_ready)
    // controller issues at most one command per cycle
    `CADI_ASSERT_IMP(a_cmd_onehot, i_clk, i_rst_n, 1'b1,
                     $onehot0({cmd.load, cmd.step, cmd.fin, cmd.commit}))
    // a found result always lands on a real month
    `CADI_ASSERT_IMP(a_found_month, i_clk, i_rst_n, out_valid && o_rsp.found,
                     o_rsp.end_month >= FIRST_MONTH && o_rsp.end_month <= MONTHS_PER_YEAR)

endmodule

@@ design/cadi_ctrl.sv @@
// Controller for the date-advance core: sequences load, month steps, day fix-up
// and commit to the output register. Depends on cadi_pkg.
module cadi_ctrl #(
    parameter int MONTH_STEPS = 13
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  cadi_pkg::t_status i_status,
    output cadi_pkg::t_cmd    o_cmd,
    output logic              o_in_ready,
    output logic              o_out_valid
);
    import cadi_pkg::*;

    localparam int STEP_W = $clog2(MONTH_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MONTH_STEPS - 1);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_WALK;
            end
            ST_WALK: begin
                if (i_status.hit) n_state = ST_FIN;
                else if (r_step == LAST_STEP) n_state = ST_DONE;
            end
            ST_FIN: n_state = ST_DONE;
            ST_DONE: begin
                if (slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                n_step     = '0;
            end
            ST_WALK: begin
                o_cmd.step = 1'b1;
                n_step     = r_step + 1'b1;
            end
            ST_FIN: o_cmd.fin = 1'b1;
            ST_DONE: begin
                if (slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ design/cadi_dp.sv @@
// Datapath for the date-advance core: working date, day tally and output
// register. Driven by cadi_ctrl commands. Depends on cadi_pkg.
module cadi_dp (
    input  logic                        i_clk,
    input  cadi_pkg::t_cmd              i_cmd,
    input  logic [cadi_pkg::YEAR_W-1:0]  i_start_year,
    input  logic [cadi_pkg::MONTH_W-1:0] i_start_month,
    input  logic [cadi_pkg::DAY_W-1:0]   i_start_day,
    input  logic [cadi_pkg::COUNT_W-1:0] i_day_count,
    output cadi_pkg::t_status           o_status,
    output logic [cadi_pkg::YEAR_W-1:0]  o_end_year,
    output logic [cadi_pkg::MONTH_W-1:0] o_end_month,
    output logic [cadi_pkg::DAY_W-1:0]   o_end_day,
    output logic                        o_found
);
    import cadi_pkg::*;

    logic [YEAR_W-1:0]  r_year, r_out_year;
    logic [MONTH_W-1:0] r_month, r_out_month;
    logic [DAY_W-1:0]   r_day, r_out_day;
    logic [COUNT_W-1:0] r_count;
    logic [TALLY_W-1:0] r_tally;
    logic               r_found, r_out_found;

    logic [YEAR_W-1:0]  adv_year, back_year;
    logic [MONTH_W-1:0] adv_month, back_month;
    logic [TALLY_W-1:0] load_tally;
    logic               hit;

    // first tally: days from the start day to the end of its month, 16-bit wrap
    assign load_tally = TALLY_W'(days_in(i_start_year, i_start_month))
                      - TALLY_W'(i_start_day) + TALLY_W'(1);

    assign hit = r_tally >= TALLY_W'(r_count);

    always_comb begin
        if (r_month >= MONTHS_PER_YEAR) begin
            adv_month = FIRST_MONTH;
            adv_year  = r_year + YEAR_W'(1);
        end else begin
            adv_month = r_month + FIRST_MONTH;
            adv_year  = r_year;
        end
    end

    // advance-then-step-back collapses to the current month, except for
    // out-of-range codes, which only occur on the first step
    always_comb begin
        back_month = r_month;
        back_year  = r_year;
        if (r_month == '0) begin
            back_month = MONTHS_PER_YEAR;
            back_year  = r_year - YEAR_W'(1);
        end else if (r_month > MONTHS_PER_YEAR) begin
            back_month = MONTHS_PER_YEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_year  <= i_start_year;
            r_month <= i_start_month;
            r_day   <= i_start_day;
            r_count <= i_day_count;
            r_tally <= load_tally;
            r_found <= 1'b0;
        end else if (i_cmd.step) begin
            if (hit) begin
                r_tally <= r_tally - TALLY_W'(r_count);
                r_month <= back_month;
                r_year  <= back_year;
                r_found <= 1'b1;
            end else begin
                r_tally <= r_tally + TALLY_W'(days_in(adv_year, adv_month));
                r_month <= adv_month;
                r_year  <= adv_year;
            end
        end else if (i_cmd.fin) begin
            // only the low DAY_W bits of the tally enter the day
            r_day <= days_in(r_year, r_month) - r_tally[DAY_W-1:0];
        end
        if (i_cmd.commit) begin
            r_out_year  <= r_year;
            r_out_month <= r_month;
            r_out_day   <= r_day;
            r_out_found <= r_found;
        end
    end

    assign o_status.hit = hit;
    assign o_end_year   = r_out_year;
    assign o_end_month  = r_out_month;
    assign o_end_day    = r_out_day;
    assign o_found      = r_out_found;

endmodule
